// ----- rtl/ctca_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the charge-time capacitance averager.
// Used by ctca_ctrl, ctca_datapath and charge_time_capacitance_averager_top.
package ctca_pkg;

  // Width and reset value of the sample-size register
  localparam int CFG_WIDTH = 8;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 8'd16;

  // Width of the average field on the result
  localparam int AVG_WIDTH = 16;

  // One tick in
  typedef struct packed {
    logic start_request;
    logic receive_level;
  } item_t;

  // One tick out
  typedef struct packed {
    logic                 send_drive;
    logic                 discharge_pulse;
    logic                 finished;
    logic [AVG_WIDTH-1:0] average_time;
  } result_t;

  // Controller states
  typedef enum logic {
    ST_RUN,
    ST_DIVIDE
  } ctca_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // apply the tick update of the accepted item
    logic step;     // advance the divider by one quotient bit
    logic finish;   // store the quotient and load the closing result
  } ctca_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_needed;  // the offered item ends a run with a non-zero size
    logic div_done;    // all quotient bits are formed
  } ctca_status_t;

endpackage

// ----- rtl/ctca_ctrl.sv -----
`timescale 1ns / 1ps
// Controller for the charge-time capacitance averager: run/divide sequencing
// and the result valid flag. Depends on ctca_pkg.
module ctca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  ctca_pkg::ctca_status_t status,
  output ctca_pkg::ctca_cmd_t    cmd,
  output ctca_pkg::ctca_state_t  state
);
  import ctca_pkg::*;

  ctca_state_t state_next;
  logic        out_free;
  logic        load_result;

  // The result register can take a new item if empty or draining this cycle
  assign out_free = !result_valid || !result_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (item_valid && out_free && status.div_needed) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_done && out_free) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    item_stall  = 1'b1;
    load_result = 1'b0;
    unique case (state)
      ST_RUN: begin
        item_stall  = !out_free;
        cmd.accept  = item_valid && out_free;
        load_result = cmd.accept && !status.div_needed;
      end
      ST_DIVIDE: begin
        cmd.step    = !status.div_done;
        cmd.finish  = status.div_done && out_free;
        load_result = cmd.finish;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/ctca_datapath.sv -----
`timescale 1ns / 1ps
// Datapath for the charge-time capacitance averager: tick update, reading sum,
// restoring divider and result register. Depends on ctca_pkg.
module ctca_datapath #(
  parameter int TIME_WIDTH  = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [ctca_pkg::CFG_WIDTH-1:0]    cfg_wdata,
  input  ctca_pkg::item_t                   item,
  input  ctca_pkg::ctca_cmd_t               cmd,
  output ctca_pkg::ctca_status_t            status,
  output ctca_pkg::result_t                 result
);
  import ctca_pkg::*;

  localparam int SUM_W = TIME_WIDTH + COUNT_WIDTH;
  localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int CNT_W = $clog2(SUM_W + 1);

  // Registers
  logic [CFG_WIDTH-1:0]   sample_size;
  logic                   sampling_active;
  logic                   charging_wait;
  logic [TIME_WIDTH-1:0]  charge_timer;
  logic [SUM_W-1:0]       reading_sum;
  logic [COUNT_WIDTH-1:0] readings_taken;
  logic [TIME_WIDTH-1:0]  stored_average;
  logic [SUM_W-1:0]       div_quot;
  logic [COUNT_WIDTH:0]   div_rem;
  logic [COUNT_WIDTH-1:0] div_divisor;
  logic [CNT_W-1:0]       div_count;

  // Tick update values
  logic                   sampling_active_next;
  logic                   charging_wait_next;
  logic [TIME_WIDTH-1:0]  charge_timer_next;
  logic [SUM_W-1:0]       reading_sum_next;
  logic [COUNT_WIDTH-1:0] readings_taken_next;
  logic [TIME_WIDTH-1:0]  stored_average_next;
  logic                   pulse;
  logic                   div_needed;
  logic                   active_now;
  logic [TIME_WIDTH-1:0]  timer_now;

  // Effective sample size, limited to the counter range
  logic [CMP_W-1:0]       size_wide;
  logic [CMP_W-1:0]       count_max_wide;
  logic [COUNT_WIDTH-1:0] size_eff;

  // Divider step
  logic [COUNT_WIDTH:0]   rem_sh;
  logic [COUNT_WIDTH+1:0] trial;
  logic                   fits;

  // Result assembly
  logic [TIME_WIDTH-1:0]           avg_out;
  logic [TIME_WIDTH+AVG_WIDTH-1:0] avg_ext;
  result_t                         result_next;

  assign size_wide      = CMP_W'(sample_size);
  assign count_max_wide = CMP_W'({COUNT_WIDTH{1'b1}});
  assign size_eff       = (size_wide > count_max_wide) ? {COUNT_WIDTH{1'b1}}
                                                       : size_wide[COUNT_WIDTH-1:0];

  // Work out the state after one tick
  always_comb begin
    sampling_active_next = sampling_active;
    charging_wait_next   = charging_wait;
    charge_timer_next    = charge_timer;
    reading_sum_next     = reading_sum;
    readings_taken_next  = readings_taken;
    stored_average_next  = stored_average;
    pulse                = 1'b0;
    div_needed           = 1'b0;
    active_now           = sampling_active || item.start_request;
    timer_now            = charging_wait ? charge_timer : '0;
    if (active_now) begin
      sampling_active_next = 1'b1;
      charging_wait_next   = 1'b1;
      charge_timer_next    = timer_now;
      if (item.receive_level) begin
        charging_wait_next = 1'b0;
        pulse              = 1'b1;
        if (readings_taken < size_eff) begin
          reading_sum_next    = reading_sum + SUM_W'(timer_now);
          readings_taken_next = readings_taken + 1'b1;
        end else begin
          // End of run: a zero size stores zero, otherwise divide
          if (size_eff == '0) begin
            stored_average_next = '0;
          end else begin
            div_needed = 1'b1;
          end
          reading_sum_next     = '0;
          readings_taken_next  = '0;
          sampling_active_next = 1'b0;
        end
      end else if (!(&timer_now)) begin
        charge_timer_next = timer_now + 1'b1;
      end
    end
  end

  assign status.div_needed = div_needed;
  assign status.div_done   = (div_count == '0);

  // One restoring division step
  assign rem_sh = {div_rem[COUNT_WIDTH-1:0], div_quot[SUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, div_divisor};
  assign fits   = !trial[COUNT_WIDTH+1];

  // Build the result payload
  assign avg_out = cmd.finish ? div_quot[TIME_WIDTH-1:0] : stored_average_next;
  assign avg_ext = {{AVG_WIDTH{1'b0}}, avg_out};

  always_comb begin
    result_next.average_time = avg_ext[AVG_WIDTH-1:0];
    if (cmd.finish) begin
      result_next.send_drive      = 1'b0;
      result_next.discharge_pulse = 1'b1;
      result_next.finished        = 1'b1;
    end else begin
      result_next.send_drive      = charging_wait_next;
      result_next.discharge_pulse = pulse;
      result_next.finished        = !sampling_active_next;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_size     <= CFG_RESET;
      sampling_active <= 1'b0;
      charging_wait   <= 1'b0;
      charge_timer    <= '0;
      reading_sum     <= '0;
      readings_taken  <= '0;
      stored_average  <= '0;
      div_count       <= '0;
    end else if (cfg_wen) begin
      sample_size    <= cfg_wdata;
      reading_sum    <= '0;
      readings_taken <= '0;
    end else if (cmd.accept) begin
      sampling_active <= sampling_active_next;
      charging_wait   <= charging_wait_next;
      charge_timer    <= charge_timer_next;
      reading_sum     <= reading_sum_next;
      readings_taken  <= readings_taken_next;
      stored_average  <= stored_average_next;
      if (div_needed) begin
        div_count <= CNT_W'(SUM_W);
      end
    end else if (cmd.step) begin
      div_count <= div_count - 1'b1;
    end else if (cmd.finish) begin
      stored_average <= div_quot[TIME_WIDTH-1:0];
    end
  end

  // Divider registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept && div_needed) begin
      div_quot    <= reading_sum;
      div_rem     <= '0;
      div_divisor <= size_eff;
    end else if (cmd.step) begin
      div_quot <= {div_quot[SUM_W-2:0], fits};
      div_rem  <= fits ? trial[COUNT_WIDTH:0] : rem_sh;
    end
    if ((cmd.accept && !div_needed) || cmd.finish) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/charge_time_capacitance_averager_top.sv -----
`timescale 1ns / 1ps
// Top level of the charge-time capacitance averager.
// Depends on ctca_pkg, ctca_ctrl and ctca_datapath.
//
// Each item is one microsecond tick and gives one result item. An ordinary
// tick needs no division. The tick that ends a sampling run with a non-zero
// sample size runs a restoring divider, one quotient bit a cycle, over
// TIME_WIDTH + COUNT_WIDTH bits; no item is taken until the quotient is done.
// The result register lets an item be taken in the cycle its predecessor's
// result leaves. The user must write the sample size through cfg_wen /
// cfg_wdata only while the block is idle; the block does not enforce this.
// A write clears the running sum and reading count.
module charge_time_capacitance_averager_top #(
  parameter int TIME_WIDTH  = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [ctca_pkg::CFG_WIDTH-1:0] cfg_wdata,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  ctca_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output ctca_pkg::result_t              result
);
  import ctca_pkg::*;

  ctca_cmd_t    cmd;
  ctca_status_t status;
  ctca_state_t  state;

  // Sequencing
  ctca_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd),
    .state        (state)
  );

  // Tick update, sum and divider
  ctca_datapath #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // An item that needs no division shows its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !status.div_needed) |=> result_valid)
    else $error("result missing after a plain tick");

  // No item is taken while a division is in progress
  a_hold_in_divide: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> item_stall)
    else $error("item taken during division");

  // A charging result never reports the run as finished
  a_drive_not_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.send_drive) |-> !result.finished)
    else $error("send drive high with run finished");

endmodule
